// ===== rtl/quad_corner_match_search_unit_defines.svh =====
`ifndef QUAD_CORNER_MATCH_SEARCH_UNIT_DEFINES_SVH
`define QUAD_CORNER_MATCH_SEARCH_UNIT_DEFINES_SVH

// checks a property on every clock edge outside reset
`define QCMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checks that a condition implies a consequence in the following cycle
`define QCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qcms_pkg.sv =====
`default_nettype none
package qcms_pkg;
	localparam int unsigned MaxCandidatesDefault = 64;
	localparam int unsigned CoordW = 16;
	localparam int unsigned DistW = 17;
	localparam int unsigned ErrW = 19;
	localparam int unsigned IndexW = 6;
	localparam int unsigned RadW = 34;
	localparam logic [DistW-1:0] LimitReset = 17'd92681;
	localparam logic [ErrW-1:0] NoMatch = '1;
	localparam logic OpReference = 1'b0;
	localparam logic OpCandidate = 1'b1;
	localparam logic [1:0] LastCorner = 2'd3;

	typedef struct packed {
		logic op;
		logic [1:0] corner;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic last;
		logic score;
	} qcms_item_t;
endpackage
`default_nettype wire

// ===== rtl/qcms_front.sv =====
`default_nettype none
module qcms_front
	import qcms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic operation,
	input wire logic [1:0] corner_index,
	input wire logic signed [CoordW-1:0] point_x,
	input wire logic signed [CoordW-1:0] point_y,
	input wire logic last_candidate,
	output qcms_item_t head,
	output logic head_valid,
	input wire logic pop
);
	qcms_item_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic push;
	qcms_item_t item;

	always_comb begin
		item.op = operation;
		item.corner = corner_index;
		item.x = point_x;
		item.y = point_y;
		item.last = last_candidate;
		item.score = (operation == OpCandidate) && (corner_index == LastCorner);
	end

	assign in_stall = fill_q == 2'd2;
	assign push = in_valid && !in_stall;
	assign head_valid = fill_q != 2'd0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/qcms_back.sv =====
`default_nettype none
module qcms_back
	import qcms_pkg::*;
#(
	parameter int unsigned MAX_CANDIDATES = MaxCandidatesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire qcms_item_t head,
	input wire logic head_valid,
	output logic pop,
	input wire logic cfg_we,
	input wire logic [DistW-1:0] cfg_limit,
	output logic out_valid,
	input wire logic out_stall,
	output logic found,
	output logic [IndexW-1:0] best_index,
	output logic [ErrW-1:0] best_error,
	output logic overflow
);
	localparam int unsigned CntW = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_CANDIDATES);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDiff = 3'd1;
	localparam logic [2:0] StSq = 3'd2;
	localparam logic [2:0] StAdd = 3'd3;
	localparam logic [2:0] StRoot = 3'd4;
	localparam logic [2:0] StPick = 3'd5;
	localparam logic [2:0] StDone = 3'd6;
	localparam logic [2:0] StEmit = 3'd7;

	logic [2:0] state_q;
	logic signed [CoordW-1:0] refx_q [4];
	logic signed [CoordW-1:0] refy_q [4];
	logic signed [CoordW-1:0] candx_q [4];
	logic signed [CoordW-1:0] candy_q [4];
	logic [DistW-1:0] limit_q, lim_q;
	logic [1:0] i_q, j_q, pick_q;
	logic pick_ok_q, last_q, ovf_q;
	logic [3:0] taken_q;
	logic [ErrW-1:0] sum_q, best_q;
	logic [CntW-1:0] count_q, best_pos_q;
	logic [CoordW-1:0] ux_q, uy_q;
	logic [2*CoordW-1:0] sqx_q, sqy_q;
	logic [RadW-1:0] rad_q;
	logic [ErrW-1:0] rem_q;
	logic [DistW-1:0] root_q;
	logic [4:0] iter_q;
	logic out_valid_q, found_q, ovf_out_q;
	logic [IndexW-1:0] idx_out_q;
	logic [ErrW-1:0] err_out_q;

	logic signed [CoordW:0] dx, dy;
	logic [ErrW-1:0] rem_sh, trial;
	logic d_lt, nok;
	logic [DistW-1:0] nlim;
	logic [1:0] npick;
	logic [ErrW-1:0] nsum;
	logic emit_go;
	logic load_out;

	assign pop = (state_q == StIdle) && head_valid;
	assign dx = {refx_q[i_q][CoordW-1], refx_q[i_q]} - {candx_q[j_q][CoordW-1], candx_q[j_q]};
	assign dy = {refy_q[i_q][CoordW-1], refy_q[i_q]} - {candy_q[j_q][CoordW-1], candy_q[j_q]};
	assign rem_sh = {rem_q[ErrW-3:0], rad_q[RadW-1:RadW-2]};
	assign trial = ErrW'({root_q[DistW-2:0], 2'b01});
	assign d_lt = root_q < lim_q;
	assign nlim = d_lt ? root_q : lim_q;
	assign npick = d_lt ? j_q : pick_q;
	assign nok = d_lt || pick_ok_q;
	assign nsum = sum_q + ErrW'(nlim);
	assign emit_go = !out_valid_q || !out_stall;
	assign load_out = (state_q == StEmit) && emit_go;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.op == OpReference) begin
				refx_q[head.corner] <= head.x;
				refy_q[head.corner] <= head.y;
			end else begin
				candx_q[head.corner] <= head.x;
				candy_q[head.corner] <= head.y;
			end
		end
		if (state_q == StDiff) begin
			ux_q <= CoordW'(dx[CoordW] ? -dx : dx);
			uy_q <= CoordW'(dy[CoordW] ? -dy : dy);
		end
		if (state_q == StSq) begin
			sqx_q <= ux_q * ux_q;
			sqy_q <= uy_q * uy_q;
		end
		if (state_q == StAdd) begin
			rad_q <= RadW'(sqx_q) + RadW'(sqy_q);
			rem_q <= '0;
			root_q <= '0;
		end
		if (state_q == StRoot) begin
			rad_q <= {rad_q[RadW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[DistW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[DistW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			limit_q <= LimitReset;
			lim_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pick_q <= '0;
			pick_ok_q <= 1'b0;
			taken_q <= '0;
			sum_q <= '0;
			last_q <= 1'b0;
			best_q <= NoMatch;
			best_pos_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			iter_q <= '0;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			idx_out_q <= '0;
			err_out_q <= '0;
			ovf_out_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_limit;
			if (out_valid_q && !out_stall && !load_out) out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (pop) begin
						last_q <= head.last;
						if (head.op == OpReference) begin
							best_q <= NoMatch;
							best_pos_q <= '0;
							count_q <= '0;
							ovf_q <= 1'b0;
						end else if (head.score) begin
							if (count_q >= CntMax) begin
								ovf_q <= 1'b1;
								if (head.last) state_q <= StEmit;
							end else begin
								i_q <= '0;
								j_q <= '0;
								lim_q <= limit_q;
								pick_ok_q <= 1'b0;
								taken_q <= '0;
								sum_q <= '0;
								state_q <= StDiff;
							end
						end
					end
				end
				StDiff: state_q <= StSq;
				StSq: state_q <= StAdd;
				StAdd: begin
					iter_q <= '0;
					state_q <= StRoot;
				end
				StRoot: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(DistW - 1)) state_q <= StPick;
				end
				StPick: begin
					if (j_q != LastCorner) begin
						lim_q <= nlim;
						pick_q <= npick;
						pick_ok_q <= nok;
						j_q <= j_q + 2'd1;
						state_q <= StDiff;
					end else if (!nok || taken_q[npick]) begin
						state_q <= StDone;
					end else begin
						taken_q[npick] <= 1'b1;
						sum_q <= nsum;
						if (i_q == LastCorner) begin
							if (nsum < best_q) begin
								best_q <= nsum;
								best_pos_q <= count_q;
							end
							state_q <= StDone;
						end else begin
							i_q <= i_q + 2'd1;
							j_q <= '0;
							lim_q <= limit_q;
							pick_ok_q <= 1'b0;
							state_q <= StDiff;
						end
					end
				end
				StDone: begin
					count_q <= count_q + CntW'(1);
					state_q <= last_q ? StEmit : StIdle;
				end
				StEmit: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						found_q <= best_q != NoMatch;
						idx_out_q <= (best_q != NoMatch) ? IndexW'(best_pos_q) : '0;
						err_out_q <= (best_q != NoMatch) ? best_q : '0;
						ovf_out_q <= ovf_q;
						best_q <= NoMatch;
						best_pos_q <= '0;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign best_index = idx_out_q;
	assign best_error = err_out_q;
	assign overflow = ovf_out_q;
endmodule
`default_nettype wire

// ===== rtl/quad_corner_match_search_unit.sv =====
// quad corner match search
// input channel: in_valid/in_stall with operation, corner_index, point_x,
// point_y, last_candidate; a transfer happens when in_valid is high and
// in_stall is low. load four reference corners (operation 0), then send
// candidates as corners 0 to 3 (operation 1), last_candidate on corner 3
// of the final one.
// config channel: cfg_valid/cfg_ready with cfg_data, the corner limit;
// cfg_ready is always high.
// output channel: out_valid/out_stall with found, best_index, best_error,
// overflow; one result after each candidate group.
// a two-entry queue sits between acceptance and the scoring engine.
// reference corners and candidate corners 0 to 2 are stored without scoring.
// corner 3 runs up to 16 distances through a pair of squarers and a
// bit-per-cycle root unit, each through diff, square, add, root and pick.
// after scoring, the result passes StDone and StEmit and leaves once the output is free.
// a stalled result holds its value; scoring of the next group continues
// until a new result must be loaded.
// reset clears the queue, search state and output; limit returns to 92681.
`default_nettype none
module quad_corner_match_search_unit
	import qcms_pkg::*;
#(
	parameter int unsigned MAX_CANDIDATES = MaxCandidatesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic operation,
	input wire logic [1:0] corner_index,
	input wire logic signed [CoordW-1:0] point_x,
	input wire logic signed [CoordW-1:0] point_y,
	input wire logic last_candidate,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [DistW-1:0] cfg_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic found,
	output logic [IndexW-1:0] best_index,
	output logic [ErrW-1:0] best_error,
	output logic overflow
);
	qcms_item_t head;
	logic head_valid, pop;

	assign cfg_ready = 1'b1;

	qcms_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .corner_index,
		.point_x, .point_y, .last_candidate, .head, .head_valid, .pop
	);

	qcms_back #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
		.clk, .arst_n, .head, .head_valid, .pop,
		.cfg_we(cfg_valid && cfg_ready), .cfg_limit(cfg_data),
		.out_valid, .out_stall, .found, .best_index, .best_error, .overflow
	);
endmodule
`default_nettype wire

// ===== rtl/qcms_checker.sv =====
`default_nettype none
`include "quad_corner_match_search_unit_defines.svh"
module qcms_checker
	import qcms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic found,
	input wire logic [IndexW-1:0] best_index,
	input wire logic [ErrW-1:0] best_error,
	input wire logic overflow
);
	logic [ErrW+IndexW+1:0] held_result;

	assign held_result = {found, best_index, best_error, overflow};

	`QCMS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(held_result), "stalled result changed")
	`QCMS_ASSERT(a_none_zero, !(out_valid && !found) || (best_index == '0 && best_error == '0), "empty result not zero")
	`QCMS_ASSERT(a_err_bound, !(out_valid && found) || (best_error <= 19'd370720), "error sum out of range")
endmodule

bind quad_corner_match_search_unit qcms_checker u_chk (.*);
`default_nettype wire
